>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by neighbor_cache_table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define NCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define NCT_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define NCT_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/nct_pkg.sv
// ----------------------------------------------------------------------------
// nct_pkg
// types and constants of the ipv6 neighbor cache
// ----------------------------------------------------------------------------
package nct_pkg;

   localparam int NUM_BUCKETS = 64;
   localparam int WAYS        = 4;

   localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
   localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit BUCKET_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

   localparam int TAIL_W      = 32;

   // bucket of a tail by reciprocal multiplication, exact for every 32-bit tail
   localparam int RECIP_W     = TAIL_W + 1;
   localparam int PROD_W      = TAIL_W + RECIP_W;
   localparam int QUOT_W      = RECIP_W - BUCKET_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << (TAIL_W + BUCKET_W)) + 64'(NUM_BUCKETS) - 64'd1) /
               64'(NUM_BUCKETS));

   localparam int NS_W        = 16;
   localparam int ADDR_W      = 64;
   localparam int MAC_W       = 48;
   localparam int STATUS_W    = 3;

   typedef enum logic {
      CMD_RESOLVE  = 1'b0,
      CMD_REMEMBER = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT      = 3'd0,
      STATUS_LOOPBACK = 3'd1,
      STATUS_MISS     = 3'd2,
      STATUS_STORED   = 3'd3,
      STATUS_DROPPED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic [NS_W-1:0]   namespace_id;
      logic [ADDR_W-1:0] addr_upper;
      logic [ADDR_W-1:0] addr_lower;
      logic [MAC_W-1:0]  mac;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic             free;
      logic [WAY_W-1:0] free_way;
   } match_type;

endpackage

>>> rtl/nct_if.sv
// ----------------------------------------------------------------------------
// nct_if
// request and response channels of the neighbor cache
// ----------------------------------------------------------------------------
interface nct_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [nct_pkg::NS_W-1:0]     namespace_id;
   logic [nct_pkg::ADDR_W-1:0]   addr_upper;
   logic [nct_pkg::ADDR_W-1:0]   addr_lower;
   logic [nct_pkg::MAC_W-1:0]    link_addr;

   modport source (output valid, command, namespace_id, addr_upper, addr_lower, link_addr,
                   input ready);
   modport sink   (input valid, command, namespace_id, addr_upper, addr_lower, link_addr,
                   output ready);
endinterface

interface nct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nct_pkg::STATUS_W-1:0] status;
   logic [nct_pkg::MAC_W-1:0]    mac_found;

   modport source (output valid, status, mac_found, input ready);
   modport sink   (input valid, status, mac_found, output ready);
endinterface

>>> rtl/neighbor_cache_table.sv
// ----------------------------------------------------------------------------
// neighbor_cache_table
// set-associative ipv6 neighbor cache: resolve and remember bindings
//
//   channel   dir  handshake    payload
//   req_chan  in   valid/ready  command, namespace_id, addr_upper, addr_lower, link_addr
//   rsp_chan  out  valid/ready  status, mac_found
//
// one item at a time: bucket row read from the table memory, then
// compare and write back; with a bucket count that is not a power of two a
// reciprocal multiply and subtract add a divide state ahead of the read
// reset clears state and all valid bits together, no clearing pass
// a full response register holds the lookup step until the item is taken
// ----------------------------------------------------------------------------
module neighbor_cache_table (
   input  logic      clock,
   input  logic      reset,
   nct_req_if.sink   req_chan,
   nct_rsp_if.source rsp_chan
);

   nct_pkg::state_type state_ff, state_in;

   nct_pkg::command_type              cmd_ff;
   logic [nct_pkg::NS_W-1:0]          ns_ff;
   logic [nct_pkg::ADDR_W-1:0]        upper_ff;
   logic [nct_pkg::ADDR_W-1:0]        lower_ff;
   logic [nct_pkg::MAC_W-1:0]         link_ff;
   logic [nct_pkg::QUOT_W-1:0]        quot_ff;
   logic [nct_pkg::BUCKET_W-1:0]      bucket_ff;

   nct_pkg::row_type                  mem [nct_pkg::NUM_BUCKETS];
   logic [nct_pkg::WAYS-1:0]          valid_ff [nct_pkg::NUM_BUCKETS];
   nct_pkg::row_type                  row_ff;
   logic [nct_pkg::WAYS-1:0]          vrow_ff;

   logic                              rsp_valid_ff;
   nct_pkg::status_type               rsp_status_ff;
   logic [nct_pkg::MAC_W-1:0]         rsp_mac_ff;

   logic                              req_ready;
   logic                              req_fire;
   logic                              rsp_free;
   logic                              rsp_load;
   logic                              rd_en;
   logic [nct_pkg::BUCKET_W-1:0]      rd_addr;
   logic [nct_pkg::PROD_W-1:0]        recip_prod;
   logic [nct_pkg::TAIL_W-1:0]        rem_full;
   logic                              loopback;
   nct_pkg::match_type                match;
   nct_pkg::status_type               status_in;
   logic [nct_pkg::MAC_W-1:0]         mac_in;
   nct_pkg::row_type                  row_wr;
   logic                              mem_we;
   logic                              valid_set;

   assign req_fire  = req_chan.valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = req_ready;

   // quotient at capture, remainder in the divide cycle
   assign recip_prod = nct_pkg::PROD_W'(req_chan.addr_lower[nct_pkg::TAIL_W-1:0]) *
                       nct_pkg::PROD_W'(nct_pkg::RECIP);
   assign rem_full   = lower_ff[nct_pkg::TAIL_W-1:0] -
                       nct_pkg::TAIL_W'(quot_ff) * nct_pkg::TAIL_W'(nct_pkg::NUM_BUCKETS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rem_full[nct_pkg::BUCKET_W-1:0];
      rsp_load  = 1'b0;
      unique case (state_ff)
         nct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (nct_pkg::BUCKET_POW2) begin
                  rd_en    = 1'b1;
                  rd_addr  = req_chan.addr_lower[nct_pkg::BUCKET_W-1:0];
                  state_in = nct_pkg::ST_LOOKUP;
               end else begin
                  state_in = nct_pkg::ST_DIVIDE;
               end
            end
         end
         nct_pkg::ST_DIVIDE: begin
            rd_en    = 1'b1;
            state_in = nct_pkg::ST_LOOKUP;
         end
         nct_pkg::ST_LOOKUP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = nct_pkg::ST_IDLE;
            end
         end
         default: state_in = nct_pkg::ST_IDLE;
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= nct_pkg::command_type'(req_chan.command);
         ns_ff    <= req_chan.namespace_id;
         upper_ff <= req_chan.addr_upper;
         lower_ff <= req_chan.addr_lower;
         link_ff  <= req_chan.link_addr;
         quot_ff  <= recip_prod[nct_pkg::PROD_W-1:nct_pkg::TAIL_W+nct_pkg::BUCKET_W];
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[bucket_ff] <= row_wr;
      end
      if (rd_en) begin
         row_ff    <= mem[rd_addr];
         vrow_ff   <= valid_ff[rd_addr];
         bucket_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < nct_pkg::NUM_BUCKETS; b++) begin
            valid_ff[b] <= '0;
         end
      end else if (valid_set) begin
         valid_ff[bucket_ff][match.free_way] <= 1'b1;
      end
   end

   nct_match u_match (
      .row           (row_ff),
      .row_valid     (vrow_ff),
      .key_namespace (ns_ff),
      .key_upper     (upper_ff),
      .key_lower     (lower_ff),
      .result        (match)
   );

   assign loopback = upper_ff == '0 && lower_ff == nct_pkg::ADDR_W'(1);

   always_comb begin
      status_in = nct_pkg::STATUS_MISS;
      mac_in    = '0;
      row_wr    = row_ff;
      mem_we    = 1'b0;
      valid_set = 1'b0;
      case (cmd_ff)
         nct_pkg::CMD_RESOLVE: begin
            if (loopback) begin
               status_in = nct_pkg::STATUS_LOOPBACK;
            end else if (match.hit) begin
               status_in = nct_pkg::STATUS_HIT;
               mac_in    = row_ff[match.hit_way].mac;
            end
         end
         default: begin
            if (match.hit) begin
               status_in                  = nct_pkg::STATUS_STORED;
               row_wr[match.hit_way].mac  = link_ff;
               mem_we                     = rsp_load;
            end else if (match.free) begin
               status_in                           = nct_pkg::STATUS_STORED;
               row_wr[match.free_way].namespace_id = ns_ff;
               row_wr[match.free_way].addr_upper   = upper_ff;
               row_wr[match.free_way].addr_lower   = lower_ff;
               row_wr[match.free_way].mac          = link_ff;
               mem_we                              = rsp_load;
               valid_set                           = rsp_load;
            end else begin
               status_in = nct_pkg::STATUS_DROPPED;
            end
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         rsp_mac_ff    <= mac_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.mac_found = rsp_mac_ff;

`include "assert_macros.svh"

   `NCT_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != nct_pkg::ST_IDLE,
                    "item accepted but fsm stayed idle")
   `NCT_ASSERT_IMPL(a_write_only_remember, mem_we,
                    state_ff == nct_pkg::ST_LOOKUP && cmd_ff == nct_pkg::CMD_REMEMBER,
                    "table written outside a remember lookup")
   `NCT_ASSERT_IMPL(a_mac_zero_unless_hit,
                    rsp_valid_ff && rsp_status_ff != nct_pkg::STATUS_HIT, rsp_mac_ff == '0,
                    "nonzero mac on a result that is not a hit")
   `NCT_ASSERT_NEXT(a_load_sets_valid, rsp_load, rsp_valid_ff,
                    "response register not loaded")

endmodule

>>> rtl/nct_match.sv
// ----------------------------------------------------------------------------
// nct_match
// compares a key against the ways of one bucket row, finds the lowest free way
// ----------------------------------------------------------------------------
module nct_match (
   input  nct_pkg::row_type                 row,
   input  logic [nct_pkg::WAYS-1:0]         row_valid,
   input  logic [nct_pkg::NS_W-1:0]         key_namespace,
   input  logic [nct_pkg::ADDR_W-1:0]       key_upper,
   input  logic [nct_pkg::ADDR_W-1:0]       key_lower,
   output nct_pkg::match_type               result
);

   always_comb begin
      result = '0;
      // walk downward so the lowest way wins
      for (int w = nct_pkg::WAYS - 1; w >= 0; w--) begin
         if (row_valid[w] && row[w].namespace_id == key_namespace &&
             row[w].addr_upper == key_upper && row[w].addr_lower == key_lower) begin
            result.hit     = 1'b1;
            result.hit_way = nct_pkg::WAY_W'(w);
         end
         if (!row_valid[w]) begin
            result.free     = 1'b1;
            result.free_way = nct_pkg::WAY_W'(w);
         end
      end
   end

endmodule
